/* rtl/core/stg_pkg.sv */
// Shared types, constants and point tables for the shape trajectory generator.
// No dependencies; imported by stg_cordic and shape_trajectory_generator.
package stg_pkg;

   typedef enum logic [1:0] {
      SHAPE_CIRCLE   = 2'd0,
      SHAPE_SQUARE   = 2'd1,
      SHAPE_TRIANGLE = 2'd2,
      SHAPE_HOLD     = 2'd3
   } shape_type;

   typedef enum logic [1:0] {
      CSR_PATH_SHAPE    = 2'd0,
      CSR_CIRCLE_RATE   = 2'd1,
      CSR_SQUARE_RATE   = 2'd2,
      CSR_TRIANGLE_RATE = 2'd3
   } csr_index_type;

   localparam int RATE_W     = 24;
   localparam int STEP_IN_W  = 10;
   localparam int STEP_W     = 7;
   localparam int STEP_MIN   = 10;
   localparam int STEP_MAX   = 100;
   localparam int COORD_W    = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [RATE_W-1:0] CIRCLE_RATE_RST   = 24'd102535;
   localparam logic [RATE_W-1:0] SQUARE_RATE_RST   = 24'd273426;
   localparam logic [RATE_W-1:0] TRIANGLE_RATE_RST = 24'd205069;

   localparam int ANGLE_W            = 32;
   localparam int CORDIC_ITERS       = 16;
   localparam int CORDIC_ITER_W      = 4;
   localparam int CORDIC_GAIN_Q30    = 652032874;
   localparam int CIRCLE_RADIUS_MM   = 30;
   localparam int GAIN_SHIFT         = 14;
   localparam int CORDIC_ROUND_SHIFT = 16;

   localparam logic [ANGLE_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   localparam int T_W            = 16;
   localparam int PT_W           = 24;
   localparam int SEG_IDX_W      = 5;
   localparam int SQ_POINTS      = 24;
   localparam int SQ_SIDE_POINTS = 6;
   localparam int SQ_HALF        = 75;
   localparam int SQ_STEP        = 25;
   localparam int SQ_DIVISOR     = 3;
   localparam int TRI_VERTS      = 3;
   localparam int TRI_HALF_SIDE_Q16 = 1702675;
   localparam int TRI_R_Q16         = 1966080;
   localparam int TRI_HALF_R_Q16    = 983040;

   typedef struct packed {
      logic                 start;
      logic [ANGLE_W-1:0]   angle;
   } cordic_ctl_type;

   typedef struct packed {
      logic signed [PT_W-1:0] x0;
      logic signed [PT_W-1:0] y0;
      logic signed [PT_W-1:0] dx;
      logic signed [PT_W-1:0] dy;
   } poly_pt_type;

   // square corner path in mm/3, starting at (75,75) heading to -x
   function automatic poly_pt_type square_point(input logic [SEG_IDX_W-1:0] idx);
      poly_pt_type p;
      int pos;
      begin
         if (int'(idx) < SQ_SIDE_POINTS) begin
            pos  = int'(idx);
            p.x0 = PT_W'(SQ_HALF - SQ_STEP * pos);
            p.y0 = PT_W'(SQ_HALF);
            p.dx = PT_W'(-SQ_STEP);
            p.dy = '0;
         end else if (int'(idx) < 2 * SQ_SIDE_POINTS) begin
            pos  = int'(idx) - SQ_SIDE_POINTS;
            p.x0 = PT_W'(-SQ_HALF);
            p.y0 = PT_W'(SQ_HALF - SQ_STEP * pos);
            p.dx = '0;
            p.dy = PT_W'(-SQ_STEP);
         end else if (int'(idx) < 3 * SQ_SIDE_POINTS) begin
            pos  = int'(idx) - 2 * SQ_SIDE_POINTS;
            p.x0 = PT_W'(-SQ_HALF + SQ_STEP * pos);
            p.y0 = PT_W'(-SQ_HALF);
            p.dx = PT_W'(SQ_STEP);
            p.dy = '0;
         end else begin
            pos  = int'(idx) - 3 * SQ_SIDE_POINTS;
            p.x0 = PT_W'(SQ_HALF);
            p.y0 = PT_W'(-SQ_HALF + SQ_STEP * pos);
            p.dx = '0;
            p.dy = PT_W'(SQ_STEP);
         end
         return p;
      end
   endfunction

   // triangle vertices in Q16 mm with the edge vector to the next vertex
   function automatic poly_pt_type triangle_point(input logic [1:0] k);
      poly_pt_type p;
      begin
         case (k)
            2'd0: begin
               p.x0 = '0;
               p.y0 = PT_W'(TRI_R_Q16);
               p.dx = PT_W'(-TRI_HALF_SIDE_Q16);
               p.dy = PT_W'(-TRI_HALF_R_Q16 - TRI_R_Q16);
            end
            2'd1: begin
               p.x0 = PT_W'(-TRI_HALF_SIDE_Q16);
               p.y0 = PT_W'(-TRI_HALF_R_Q16);
               p.dx = PT_W'(2 * TRI_HALF_SIDE_Q16);
               p.dy = '0;
            end
            default: begin
               p.x0 = PT_W'(TRI_HALF_SIDE_Q16);
               p.y0 = PT_W'(-TRI_HALF_R_Q16);
               p.dx = PT_W'(-TRI_HALF_SIDE_Q16);
               p.dy = PT_W'(TRI_R_Q16 + TRI_HALF_R_Q16);
            end
         endcase
         return p;
      end
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
      logic signed [COORD_W-1:0] r;
      begin
         if (v > 64'sd32767) begin
            r = 16'sh7FFF;
         end else if (v < -64'sd32768) begin
            r = 16'sh8000;
         end else begin
            r = v[COORD_W-1:0];
         end
         return r;
      end
   endfunction

endpackage

/* rtl/core/stg_cordic.sv */
// Iterative rotation-mode CORDIC: one shift-add micro-rotation per cycle.
// Returns the quadrant-corrected, rounded circle point. Depends on stg_pkg.
module stg_cordic import stg_pkg::*; #(
   parameter int COORD_FRAC_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cordic_ctl_type                    ctl,
   output logic                              done,
   output logic signed [COORD_FRAC_BITS+8:0] cos_out,
   output logic signed [COORD_FRAC_BITS+8:0] sin_out
);

   localparam int XW = COORD_FRAC_BITS + 24;
   localparam int CW = COORD_FRAC_BITS + 9;
   localparam int ZW = ANGLE_W + 1;
   localparam int RW = XW - CORDIC_ROUND_SHIFT;
   localparam logic [63:0] GAIN_PROD = 64'(CIRCLE_RADIUS_MM) * 64'(CORDIC_GAIN_Q30);
   localparam logic [63:0] X_INIT    = (GAIN_PROD << COORD_FRAC_BITS) >> GAIN_SHIFT;
   localparam logic signed [XW-1:0] ROUND_HALF = XW'(64'd1 << (CORDIC_ROUND_SHIFT - 1));
   localparam logic [CORDIC_ITER_W-1:0] LAST_ITER = CORDIC_ITER_W'(CORDIC_ITERS - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CORDIC_ITER_W-1:0]  iter_ff, iter_in;
   logic signed [XW-1:0]      x_ff, x_in;
   logic signed [XW-1:0]      y_ff, y_in;
   logic signed [ZW-1:0]      z_ff, z_in;
   logic [1:0]                quad_ff, quad_in;

   logic signed [XW-1:0]      x_sh, y_sh;
   logic signed [ZW-1:0]      atan_z;
   logic signed [XW-1:0]      x_rnd, y_rnd;
   logic signed [CW-1:0]      c_val, s_val;

   assign x_sh   = x_ff >>> iter_ff;
   assign y_sh   = y_ff >>> iter_ff;
   assign atan_z = $signed({1'b0, ATAN_TURNS[iter_ff]});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         iter_in = '0;
         x_in    = X_INIT[XW-1:0];
         y_in    = '0;
         z_in    = $signed({3'b000, ctl.angle[ANGLE_W-3:0]});
         quad_in = ctl.angle[ANGLE_W-1:ANGLE_W-2];
      end else if (busy_ff) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_z;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_z;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == LAST_ITER) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
   end

   assign x_rnd = x_ff + ROUND_HALF;
   assign y_rnd = y_ff + ROUND_HALF;
   assign c_val = $signed({{(CW-RW){x_rnd[XW-1]}}, x_rnd[XW-1:CORDIC_ROUND_SHIFT]});
   assign s_val = $signed({{(CW-RW){y_rnd[XW-1]}}, y_rnd[XW-1:CORDIC_ROUND_SHIFT]});

   always_comb begin
      case (quad_ff)
         2'd0: begin
            cos_out = c_val;
            sin_out = s_val;
         end
         2'd1: begin
            cos_out = -s_val;
            sin_out = c_val;
         end
         2'd2: begin
            cos_out = -c_val;
            sin_out = -s_val;
         end
         default: begin
            cos_out = s_val;
            sin_out = -c_val;
         end
      endcase
   end

   assign done = done_ff;

`ifndef SYNTHESIS
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("cordic started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("cordic done held longer than one cycle");
   a_last_iter_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctl.start && iter_ff == LAST_ITER) |=> (done_ff && !busy_ff))
      else $error("cordic did not finish after last iteration");
`endif

endmodule

/* rtl/core/shape_trajectory_generator.sv */
// Shape trajectory generator: phase accumulator plus shape point generation.
// One request at a time; the next is taken the cycle after the result is registered.
// The circle result comes from the 16-step CORDIC loop in stg_cordic; the other shapes from the sequencer.
// Synchronous active-high reset: phase cleared, registers to defaults, no result pending.
// Depends on stg_pkg and stg_cordic.
module shape_trajectory_generator import stg_pkg::*; #(
   parameter int PHASE_BITS      = 32,
   parameter int COORD_FRAC_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [STEP_IN_W-1:0]       req_step_ms,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [COORD_W-1:0]  rsp_target_x,
   output logic signed [COORD_W-1:0]  rsp_target_y,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [RATE_W-1:0]          csr_wdata
);

   localparam int CW       = COORD_FRAC_BITS + 9;
   localparam int PROD_W   = RATE_W + STEP_W;
   localparam int SUM_W    = ((PHASE_BITS > PROD_W) ? PHASE_BITS : PROD_W) + 1;
   localparam int LPROD_W  = PT_W + T_W + 1;
   localparam int NUM_W    = PT_W + T_W + 2;
   localparam int SH_W     = NUM_W + COORD_FRAC_BITS;
   localparam int SQ_SHIFT = T_W;
   localparam int TRI_SHIFT = 2 * T_W;
   localparam int TW       = SH_W - TRI_SHIFT;
   localparam int QW       = SH_W - SQ_SHIFT;
   localparam int UW       = COORD_FRAC_BITS + 10;
   localparam logic signed [SH_W-1:0] TRI_ROUND = SH_W'(64'd1 << (TRI_SHIFT - 1));
   localparam logic signed [SH_W-1:0] SQ_ROUND  =
      SH_W'(64'(SQ_DIVISOR) << (SQ_SHIFT - 1));
   localparam logic signed [QW-1:0] U_OFFSET =
      QW'(64'(SQ_DIVISOR) << (COORD_FRAC_BITS + 7));
   localparam logic signed [UW:0] Q_BIAS = (UW+1)'(64'd1 << (COORD_FRAC_BITS + 7));
   localparam logic [UW-1:0] RECIP = UW'((64'd1 << UW) / 64'(SQ_DIVISOR));

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_MUL    = 11'b00000000010,
      S_ADD    = 11'b00000000100,
      S_CSTART = 11'b00000001000,
      S_CWAIT  = 11'b00000010000,
      S_SEG    = 11'b00000100000,
      S_LMUL   = 11'b00001000000,
      S_LSUM   = 11'b00010000000,
      S_LRECIP = 11'b00100000000,
      S_LFIX   = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   state_type                   state_ff, state_in;
   shape_type                   path_shape_ff, path_shape_in;
   logic [RATE_W-1:0]           circle_rate_ff, circle_rate_in;
   logic [RATE_W-1:0]           square_rate_ff, square_rate_in;
   logic [RATE_W-1:0]           triangle_rate_ff, triangle_rate_in;
   logic [PHASE_BITS-1:0]       phase_ff, phase_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [T_W-1:0]              t_ff, t_in;
   poly_pt_type                 pt_ff, pt_in;
   logic                        axis_ff, axis_in;
   logic signed [LPROD_W-1:0]   lprod_ff, lprod_in;
   logic [UW-1:0]               u_ff, u_in;
   logic [UW-1:0]               qest_ff, qest_in;
   logic signed [COORD_W-1:0]   res_x_ff, res_x_in;
   logic signed [COORD_W-1:0]   res_y_ff, res_y_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0]   rsp_x_ff, rsp_x_in;
   logic signed [COORD_W-1:0]   rsp_y_ff, rsp_y_in;

   logic [STEP_W-1:0]           step_sat;
   logic [RATE_W-1:0]           rate_sel;
   logic [SUM_W-1:0]            phase_sum;
   logic [PHASE_BITS+4:0]       sq_seg;
   logic [PHASE_BITS+1:0]       tri_seg;
   logic [PHASE_BITS+ANGLE_W-1:0] ang_ext;
   logic signed [PT_W-1:0]      d_sel, v0_sel;
   logic signed [NUM_W-1:0]     num;
   logic signed [SH_W-1:0]      shifted, tri_full, sq_full;
   logic signed [QW-1:0]        sq_q, u_full;
   logic [2*UW-1:0]             qprod;
   logic [UW+1:0]               rem;
   logic [UW-1:0]               q_fix;
   logic signed [UW:0]          sq_res;
   logic signed [63:0]          lin_wide;
   logic signed [COORD_W-1:0]   lin_sat;

   cordic_ctl_type              cordic_ctl;
   logic                        cordic_done;
   logic signed [CW-1:0]        cordic_cos, cordic_sin;

   stg_cordic #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cordic_ctl),
      .done    (cordic_done),
      .cos_out (cordic_cos),
      .sin_out (cordic_sin)
   );

   assign ang_ext          = {phase_ff, {ANGLE_W{1'b0}}};
   assign cordic_ctl.start = (state_ff == S_CSTART);
   assign cordic_ctl.angle = ang_ext[PHASE_BITS+ANGLE_W-1 -: ANGLE_W];

   always_comb begin
      if (req_step_ms < STEP_IN_W'(STEP_MIN)) begin
         step_sat = STEP_W'(STEP_MIN);
      end else if (req_step_ms > STEP_IN_W'(STEP_MAX)) begin
         step_sat = STEP_W'(STEP_MAX);
      end else begin
         step_sat = req_step_ms[STEP_W-1:0];
      end
   end

   always_comb begin
      unique case (path_shape_ff)
         SHAPE_CIRCLE:   rate_sel = circle_rate_ff;
         SHAPE_SQUARE:   rate_sel = square_rate_ff;
         SHAPE_TRIANGLE: rate_sel = triangle_rate_ff;
         default:        rate_sel = '0;
      endcase
   end

   assign phase_sum = SUM_W'(phase_ff) + SUM_W'(prod_ff);
   assign sq_seg    = ({5'b0, phase_ff} << 4) + ({5'b0, phase_ff} << 3);
   assign tri_seg   = ({2'b0, phase_ff} << 1) + {2'b0, phase_ff};

   assign d_sel    = axis_ff ? pt_ff.dy : pt_ff.dx;
   assign v0_sel   = axis_ff ? pt_ff.y0 : pt_ff.x0;
   assign num      = $signed({{(NUM_W-PT_W-T_W){v0_sel[PT_W-1]}}, v0_sel, {T_W{1'b0}}})
                   + $signed({{(NUM_W-LPROD_W){lprod_ff[LPROD_W-1]}}, lprod_ff});
   assign shifted  = $signed({num, {COORD_FRAC_BITS{1'b0}}});
   assign tri_full = shifted + TRI_ROUND;
   assign sq_full  = shifted + SQ_ROUND;
   assign sq_q     = $signed(sq_full[SH_W-1:SQ_SHIFT]);
   assign u_full   = sq_q + U_OFFSET;

   assign qprod  = {{UW{1'b0}}, u_ff} * {{UW{1'b0}}, RECIP};
   assign rem    = {2'b00, u_ff} - ({1'b0, qest_ff, 1'b0} + {2'b00, qest_ff});
   assign q_fix  = (rem >= (UW+2)'(SQ_DIVISOR)) ? (qest_ff + 1'b1) : qest_ff;
   assign sq_res = $signed({1'b0, q_fix}) - Q_BIAS;

   always_comb begin
      if (state_ff == S_LFIX) begin
         lin_wide = {{(64-UW-1){sq_res[UW]}}, sq_res};
      end else begin
         lin_wide = {{(64-TW){tri_full[SH_W-1]}}, tri_full[SH_W-1:TRI_SHIFT]};
      end
   end
   assign lin_sat = sat_coord(lin_wide);

   always_comb begin
      path_shape_in    = path_shape_ff;
      circle_rate_in   = circle_rate_ff;
      square_rate_in   = square_rate_ff;
      triangle_rate_in = triangle_rate_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATH_SHAPE:    path_shape_in    = shape_type'(csr_wdata[1:0]);
            CSR_CIRCLE_RATE:   circle_rate_in   = csr_wdata;
            CSR_SQUARE_RATE:   square_rate_in   = csr_wdata;
            CSR_TRIANGLE_RATE: triangle_rate_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      t_in         = t_ff;
      pt_in        = pt_ff;
      axis_in      = axis_ff;
      lprod_in     = lprod_ff;
      u_in         = u_ff;
      qest_in      = qest_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               step_in = step_sat;
               if (req_restart) begin
                  phase_in = '0;
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = {{STEP_W{1'b0}}, rate_sel} * {{RATE_W{1'b0}}, step_ff};
            if (path_shape_ff == SHAPE_HOLD) begin
               res_x_in = '0;
               res_y_in = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            phase_in = phase_sum[PHASE_BITS-1:0];
            state_in = (path_shape_ff == SHAPE_CIRCLE) ? S_CSTART : S_SEG;
         end
         S_CSTART: begin
            state_in = S_CWAIT;
         end
         S_CWAIT: begin
            if (cordic_done) begin
               res_x_in = sat_coord({{(64-CW){cordic_cos[CW-1]}}, cordic_cos});
               res_y_in = sat_coord({{(64-CW){cordic_sin[CW-1]}}, cordic_sin});
               state_in = S_DONE;
            end
         end
         S_SEG: begin
            if (path_shape_ff == SHAPE_SQUARE) begin
               t_in  = sq_seg[PHASE_BITS-1 -: T_W];
               pt_in = square_point(sq_seg[PHASE_BITS+4:PHASE_BITS]);
            end else begin
               t_in  = tri_seg[PHASE_BITS-1 -: T_W];
               pt_in = triangle_point(tri_seg[PHASE_BITS+1:PHASE_BITS]);
            end
            axis_in  = 1'b0;
            state_in = S_LMUL;
         end
         S_LMUL: begin
            lprod_in = $signed({1'b0, t_ff}) * d_sel;
            state_in = S_LSUM;
         end
         S_LSUM, S_LFIX: begin
            if (state_ff == S_LSUM && path_shape_ff == SHAPE_SQUARE) begin
               u_in     = u_full[UW-1:0];
               state_in = S_LRECIP;
            end else begin
               if (!axis_ff) begin
                  res_x_in = lin_sat;
                  axis_in  = 1'b1;
                  state_in = S_LMUL;
               end else begin
                  res_y_in = lin_sat;
                  state_in = S_DONE;
               end
            end
         end
         S_LRECIP: begin
            qest_in  = qprod[2*UW-1:UW];
            state_in = S_LFIX;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         path_shape_ff    <= SHAPE_CIRCLE;
         circle_rate_ff   <= CIRCLE_RATE_RST;
         square_rate_ff   <= SQUARE_RATE_RST;
         triangle_rate_ff <= TRIANGLE_RATE_RST;
         phase_ff         <= '0;
         axis_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         path_shape_ff    <= path_shape_in;
         circle_rate_ff   <= circle_rate_in;
         square_rate_ff   <= square_rate_in;
         triangle_rate_ff <= triangle_rate_in;
         phase_ff         <= phase_in;
         axis_ff          <= axis_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      step_ff  <= step_in;
      prod_ff  <= prod_in;
      t_ff     <= t_in;
      pt_ff    <= pt_in;
      lprod_ff <= lprod_in;
      u_ff     <= u_in;
      qest_ff  <= qest_in;
      res_x_ff <= res_x_in;
      res_y_ff <= res_y_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_target_x = rsp_x_ff;
   assign rsp_target_y = rsp_y_ff;

`ifndef SYNTHESIS
   a_cordic_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == S_CWAIT)
      else $error("cordic result outside wait state");
   a_hold_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && path_shape_ff == SHAPE_HOLD) |=> $stable(phase_ff))
      else $error("phase moved on hold shape");
   a_add_not_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADD |-> path_shape_ff != SHAPE_HOLD)
      else $error("phase advance on hold shape");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside done state");
`endif

endmodule

/* tb/sv/tb_shape_trajectory_generator.sv */
// Self-checking testbench for shape_trajectory_generator: directed and random ticks.
// A local path predictor supplies the expected targets. Register writes happen only while idle.
// Depends on stg_pkg and the shape_trajectory_generator RTL.
module tb_shape_trajectory_generator;
   import stg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int MAX_WAIT     = 18;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } target_point_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [STEP_IN_W-1:0]        req_step_ms = '0;
   logic                        req_restart = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [COORD_W-1:0]   rsp_target_x;
   logic signed [COORD_W-1:0]   rsp_target_y;
   logic                        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [RATE_W-1:0]           csr_wdata = '0;

   shape_trajectory_generator dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_step_ms  (req_step_ms),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_target_x (rsp_target_x),
      .rsp_target_y (rsp_target_y),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [31:0]       phase_acc;
   shape_type         shape_sel;
   logic [RATE_W-1:0] rate_circle;
   logic [RATE_W-1:0] rate_square;
   logic [RATE_W-1:0] rate_triangle;

   target_point_type expected_targets [$];
   target_point_type want;
   int               mismatch_count = 0;
   int               sink_wait = 0;
   int               cycle_count = 0;
   bit               back_to_back = 1'b0;

   longint atan_turns [16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
   };
   longint tri_vx [3] = '{0, -1702675, 1702675};
   longint tri_vy [3] = '{1966080, -983040, -983040};

   function automatic logic [COORD_W-1:0] to_coord(input longint v);
      if (v > 32767) begin
         return 16'h7FFF;
      end else if (v < -32768) begin
         return 16'h8000;
      end
      return v[COORD_W-1:0];
   endfunction

   function automatic longint floor_div(input longint n, input longint d);
      longint q;
      q = n / d;
      if (n < 0 && (n % d) != 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   // perimeter position in mm/3, 600 per lap, from (75,75) heading to -x
   function automatic void square_perim(input longint v, output longint x, output longint y);
      if (v < 150) begin
         x = 75 - v;
         y = 75;
      end else if (v < 300) begin
         x = -75;
         y = 75 - (v - 150);
      end else if (v < 450) begin
         x = -75 + (v - 300);
         y = -75;
      end else begin
         x = 75;
         y = -75 + (v - 450);
      end
   endfunction

   function automatic target_point_type trace_point(input logic [31:0] ph, input shape_type sh);
      longint           cx, cy, cz, nx, ny, c, s, t;
      longint           x0, y0, x1, y1, px, py;
      logic [63:0]      seg;
      int               idx, k, k1;
      target_point_type p;
      px = 0;
      py = 0;
      case (sh)
         SHAPE_CIRCLE: begin
            cz = longint'(ph[29:0]);
            cx = longint'((64'd30 * 64'd652032874 * 64'd1024) >> 14);
            cy = 0;
            for (int i = 0; i < 16; i++) begin
               if (cz >= 0) begin
                  nx = cx - (cy >>> i);
                  ny = cy + (cx >>> i);
                  cz = cz - atan_turns[i];
               end else begin
                  nx = cx + (cy >>> i);
                  ny = cy - (cx >>> i);
                  cz = cz + atan_turns[i];
               end
               cx = nx;
               cy = ny;
            end
            c = (cx + 32768) >>> 16;
            s = (cy + 32768) >>> 16;
            case (ph[31:30])
               2'd0: begin px = c;  py = s;  end
               2'd1: begin px = -s; py = c;  end
               2'd2: begin px = -c; py = -s; end
               default: begin px = s; py = -c; end
            endcase
         end
         SHAPE_SQUARE: begin
            seg = 64'(ph) * 64'd24;
            idx = int'(seg[63:32]) % 24;
            t   = longint'(seg[31:16]);
            square_perim(idx * 25, x0, y0);
            square_perim(((idx + 1) % 24) * 25, x1, y1);
            px = floor_div((x0 * 65536 + t * (x1 - x0)) * 1024 + 98304, 196608);
            py = floor_div((y0 * 65536 + t * (y1 - y0)) * 1024 + 98304, 196608);
         end
         SHAPE_TRIANGLE: begin
            seg = 64'(ph) * 64'd3;
            k   = int'(seg[63:32]) % 3;
            k1  = (k + 1) % 3;
            t   = longint'(seg[31:16]);
            px = ((tri_vx[k] * 65536 + t * (tri_vx[k1] - tri_vx[k])) * 1024
                  + 64'sd2147483648) >>> 32;
            py = ((tri_vy[k] * 65536 + t * (tri_vy[k1] - tri_vy[k])) * 1024
                  + 64'sd2147483648) >>> 32;
         end
         default: begin
            px = 0;
            py = 0;
         end
      endcase
      p.x = to_coord(px);
      p.y = to_coord(py);
      return p;
   endfunction

   function automatic target_point_type predict_tick(input logic [STEP_IN_W-1:0] step_in,
                                                     input logic restart);
      logic [6:0]        step;
      logic [RATE_W-1:0] rate;
      target_point_type  p;
      if (step_in < 10) begin
         step = 7'd10;
      end else if (step_in > 100) begin
         step = 7'd100;
      end else begin
         step = step_in[6:0];
      end
      if (restart) begin
         phase_acc = '0;
      end
      p = '0;
      if (shape_sel != SHAPE_HOLD) begin
         rate = (shape_sel == SHAPE_CIRCLE) ? rate_circle :
                (shape_sel == SHAPE_SQUARE) ? rate_square : rate_triangle;
         phase_acc = phase_acc + rate * step;
         p = trace_point(phase_acc, shape_sel);
      end
      return p;
   endfunction

   function automatic int draw_wait();
      return back_to_back ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase_acc     = '0;
         shape_sel     = SHAPE_CIRCLE;
         rate_circle   = 24'd102535;
         rate_square   = 24'd273426;
         rate_triangle = 24'd205069;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PATH_SHAPE:    shape_sel = shape_type'(csr_wdata[1:0]);
               CSR_CIRCLE_RATE:   rate_circle = csr_wdata;
               CSR_SQUARE_RATE:   rate_square = csr_wdata;
               CSR_TRIANGLE_RATE: rate_triangle = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_targets.push_back(predict_tick(req_step_ms, req_restart));
         end
         if (rsp_valid && rsp_ready) begin
            sink_wait = draw_wait();
            if (expected_targets.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result x %0d y %0d", $time,
                        rsp_target_x, rsp_target_y);
            end else begin
               want = expected_targets.pop_front();
               if (rsp_target_x !== want.x) begin
                  mismatch_count++;
                  $display("%0t: target_x expected %0d got %0d", $time,
                           $signed(want.x), rsp_target_x);
               end
               if (rsp_target_y !== want.y) begin
                  mismatch_count++;
                  $display("%0t: target_y expected %0d got %0d", $time,
                           $signed(want.y), rsp_target_y);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (sink_wait > 0) begin
         rsp_ready <= 1'b0;
         sink_wait = sink_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_shape_trajectory_generator failed");
         $finish;
      end
   end

   task automatic send_tick(input logic [STEP_IN_W-1:0] step, input logic restart);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_step_ms <= step;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold requests until every result is back and the block is quiet
   task automatic pause_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_targets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [RATE_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [RATE_W-1:0] pick_rate(input logic [RATE_W-1:0] dflt);
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return dflt;
         default: return RATE_W'($urandom);
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_tick(10'd30, 1'b1);
      send_tick(10'd30, 1'b0);
   endtask

   task automatic test_step_saturation();
      send_tick(10'd0, 1'b0);
      send_tick(10'd9, 1'b0);
      send_tick(10'd10, 1'b0);
      send_tick(10'd101, 1'b0);
      send_tick(10'd1023, 1'b0);
   endtask

   task automatic test_circle_quadrants();
      pause_requests();
      write_reg(CSR_CIRCLE_RATE, '0);
      send_tick(10'd50, 1'b1);
      pause_requests();
      write_reg(CSR_CIRCLE_RATE, '1);
      send_tick(10'd100, 1'b0);
      send_tick(10'd100, 1'b0);
      send_tick(10'd100, 1'b0);
   endtask

   task automatic test_square_path();
      pause_requests();
      write_reg(CSR_PATH_SHAPE, 24'(SHAPE_SQUARE));
      write_reg(CSR_SQUARE_RATE, '0);
      send_tick(10'd20, 1'b1);
      pause_requests();
      write_reg(CSR_SQUARE_RATE, '1);
      send_tick(10'd100, 1'b0);
      send_tick(10'd100, 1'b0);
      send_tick(10'd100, 1'b0);
   endtask

   task automatic test_triangle_path();
      pause_requests();
      write_reg(CSR_PATH_SHAPE, 24'(SHAPE_TRIANGLE));
      write_reg(CSR_TRIANGLE_RATE, '0);
      send_tick(10'd40, 1'b1);
      pause_requests();
      write_reg(CSR_TRIANGLE_RATE, '1);
      send_tick(10'd100, 1'b0);
      send_tick(10'd100, 1'b0);
   endtask

   task automatic test_hold_shape();
      pause_requests();
      write_reg(CSR_PATH_SHAPE, 24'(SHAPE_HOLD));
      send_tick(10'd50, 1'b0);
      send_tick(10'd50, 1'b1);
      pause_requests();
      write_reg(CSR_PATH_SHAPE, 24'(SHAPE_CIRCLE));
      send_tick(10'd10, 1'b0);
   endtask

   task automatic test_wide_write();
      pause_requests();
      write_reg(CSR_PATH_SHAPE, 24'hFFFFFD);
      send_tick(10'd77, 1'b0);
      pause_requests();
      write_reg(CSR_PATH_SHAPE, 24'hABCDE0);
      send_tick(10'd64, 1'b0);
   endtask

   task automatic test_random_paths();
      int          count;
      logic [9:0]  step;
      for (int ph = 0; ph < 21; ph++) begin
         pause_requests();
         write_reg(CSR_CIRCLE_RATE, pick_rate(24'd102535));
         write_reg(CSR_SQUARE_RATE, pick_rate(24'd273426));
         write_reg(CSR_TRIANGLE_RATE, pick_rate(24'd205069));
         write_reg(CSR_PATH_SHAPE, {22'($urandom), 2'($urandom_range(0, 3))});
         back_to_back = ($urandom_range(0, 3) == 0);
         count = $urandom_range(40, 60);
         for (int i = 0; i < count; i++) begin
            if (ph == 10 && i == count / 2) begin
               pause_requests();
            end
            if ($urandom_range(0, 9) < 7) begin
               step = 10'($urandom_range(10, 100));
            end else begin
               step = 10'($urandom_range(0, 1023));
            end
            send_tick(step, $urandom_range(0, 7) == 0);
         end
      end
      back_to_back = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_step_saturation();
      test_circle_quadrants();
      test_square_path();
      test_triangle_path();
      test_hold_shape();
      test_wide_write();
      test_random_paths();
      pause_requests();
      if (mismatch_count == 0) begin
         $display("tb_shape_trajectory_generator passed");
      end else begin
         $display("tb_shape_trajectory_generator failed");
      end
      $finish;
   end

endmodule
